>>> src/focus_break_countdown_timer_macros.svh
// assertion macros for the focus/break timer checker
`ifndef FOCUS_BREAK_COUNTDOWN_TIMER_MACROS_SVH
`define FOCUS_BREAK_COUNTDOWN_TIMER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define FBCT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication, sampled on clk, off during reset
`define FBCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> src/fbct_pkg.sv
// shared types, codes and constants of the focus/break countdown timer
`default_nettype none

package fbct_pkg;

  localparam int unsigned SecW  = 17;
  localparam int unsigned MsW   = 27;
  localparam int unsigned TimeW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned IdxW  = 2;

  localparam logic [SecW-1:0] MAX_SECONDS  = SecW'(86399);
  localparam logic [MsW-1:0]  MS_PER_SEC   = MsW'(1000);
  localparam logic [MsW-1:0]  FOCUS_RST_MS = MsW'(1500000);
  localparam logic [MsW-1:0]  BREAK_RST_MS = MsW'(300000);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FOCUS = 2'd1,
    PH_BREAK = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  typedef enum logic [OpW-1:0] {
    OP_TICK        = 3'd0,
    OP_START_FOCUS = 3'd1,
    OP_PAUSE_FOCUS = 3'd2,
    OP_RESET_FOCUS = 3'd3,
    OP_START_TIMER = 3'd4,
    OP_PAUSE_TIMER = 3'd5,
    OP_RESET_TIMER = 3'd6
  } op_t;

  typedef enum logic [IdxW-1:0] {
    REG_FOCUS_PRESET = 2'd0,
    REG_BREAK_PRESET = 2'd1
  } reg_idx_t;

  // one command as held in the input register
  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TimeW-1:0] now_ms;
    logic [MsW-1:0]   start_ms;
  } cmd_t;

  // full status after the last command
  typedef struct packed {
    logic [1:0]     phase;
    logic [MsW-1:0] focus_left_ms;
    logic           focus_active;
    logic [MsW-1:0] break_left_ms;
    logic           break_active;
    logic [MsW-1:0] timer_left_ms;
    logic           timer_active;
    logic           session_running;
  } status_t;

  // saturate to one day minus a second, then scale to milliseconds
  function automatic logic [MsW-1:0] sec_to_ms(input logic [SecW-1:0] secs);
    logic [SecW-1:0] s;
    s = (secs > MAX_SECONDS) ? MAX_SECONDS : secs;
    return MsW'(MsW'(s) * MS_PER_SEC);
  endfunction

endpackage

`default_nettype wire

>>> src/focus_break_countdown_timer.sv
// Focus/break countdown timer with an independent general timer, in milliseconds.
// Each request is one command; every command returns one status result. An
// accepted request is held in the input register (its seconds field is saturated
// and scaled to milliseconds on the way in), then the command is applied to the
// session registers, which double as the result register. One command completes
// per cycle while the receiver does not stall, set by the single read-modify-write
// of the session registers; a request is still taken while a result waits, until
// the input register is also full. Preset writes are scaled to milliseconds when
// written and are taken at any cycle (cfg_ready is always high).
`default_nettype none

module focus_break_countdown_timer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fbct_pkg::OpW-1:0]      in_op,
  input  wire logic [fbct_pkg::TimeW-1:0]    in_now_ms,
  input  wire logic [fbct_pkg::SecW-1:0]     in_start_seconds,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [1:0]                    out_phase,
  output logic      [fbct_pkg::MsW-1:0]      out_focus_left_ms,
  output logic                               out_focus_active,
  output logic      [fbct_pkg::MsW-1:0]      out_break_left_ms,
  output logic                               out_break_active,
  output logic      [fbct_pkg::MsW-1:0]      out_timer_left_ms,
  output logic                               out_timer_active,
  output logic                               out_session_running,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fbct_pkg::IdxW-1:0]     cfg_index,
  input  wire logic [fbct_pkg::SecW-1:0]     cfg_data
);

  logic                       cmd_valid_r;
  fbct_pkg::cmd_t             cmd_r;
  logic                       out_valid_r;
  logic                       fire;
  logic                       in_take;
  logic [fbct_pkg::MsW-1:0]   focus_preset_ms_r;
  logic [fbct_pkg::MsW-1:0]   break_preset_ms_r;
  fbct_pkg::status_t          status;

  // apply the held command when the result slot is free or draining
  assign fire     = cmd_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = cmd_valid_r && !fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (in_take) begin
      cmd_valid_r <= 1'b1;
    end else if (fire) begin
      cmd_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_r.op       <= in_op;
      cmd_r.now_ms   <= in_now_ms;
      cmd_r.start_ms <= fbct_pkg::sec_to_ms(in_start_seconds);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_preset_ms_r <= fbct_pkg::FOCUS_RST_MS;
      break_preset_ms_r <= fbct_pkg::BREAK_RST_MS;
    end else if (cfg_valid) begin
      case (cfg_index)
        fbct_pkg::REG_FOCUS_PRESET: focus_preset_ms_r <= fbct_pkg::sec_to_ms(cfg_data);
        fbct_pkg::REG_BREAK_PRESET: break_preset_ms_r <= fbct_pkg::sec_to_ms(cfg_data);
        default: ;
      endcase
    end
  end

  fbct_exec u_exec (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .cmd             (cmd_r),
    .focus_preset_ms (focus_preset_ms_r),
    .break_preset_ms (break_preset_ms_r),
    .status          (status)
  );

  assign out_valid           = out_valid_r;
  assign out_phase           = status.phase;
  assign out_focus_left_ms   = status.focus_left_ms;
  assign out_focus_active    = status.focus_active;
  assign out_break_left_ms   = status.break_left_ms;
  assign out_break_active    = status.break_active;
  assign out_timer_left_ms   = status.timer_left_ms;
  assign out_timer_active    = status.timer_active;
  assign out_session_running = status.session_running;

endmodule

`default_nettype wire

>>> src/fbct_countdown.sv
// one saturating millisecond countdown with its run flag
`default_nettype none

module fbct_countdown (
  input  wire logic                          apply,
  input  wire logic [fbct_pkg::MsW-1:0]      left,
  input  wire logic                          run,
  input  wire logic [fbct_pkg::TimeW-1:0]    elapsed,
  output logic      [fbct_pkg::MsW-1:0]      left_nxt,
  output logic                               run_nxt
);

  logic expired;

  assign expired = (elapsed >= fbct_pkg::TimeW'(left));

  always_comb begin
    left_nxt = left;
    run_nxt  = run;
    if (apply) begin
      if (left == '0) begin
        run_nxt = 1'b0;
      end else if (run) begin
        if (expired) begin
          left_nxt = '0;
          run_nxt  = 1'b0;
        end else begin
          left_nxt = left - elapsed[fbct_pkg::MsW-1:0];
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> src/fbct_exec.sv
// session state registers and the per-command update
`default_nettype none

module fbct_exec (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       fire,
  input  wire fbct_pkg::cmd_t             cmd,
  input  wire logic [fbct_pkg::MsW-1:0]   focus_preset_ms,
  input  wire logic [fbct_pkg::MsW-1:0]   break_preset_ms,
  output fbct_pkg::status_t               status
);

  fbct_pkg::phase_t               phase_r, phase_nxt;
  logic [fbct_pkg::MsW-1:0]       focus_left_r, focus_left_nxt;
  logic                           focus_run_r, focus_run_nxt;
  logic [fbct_pkg::MsW-1:0]       break_total_r, break_total_nxt;
  logic [fbct_pkg::MsW-1:0]       break_left_r, break_left_nxt;
  logic                           break_run_r, break_run_nxt;
  logic [fbct_pkg::MsW-1:0]       timer_left_r, timer_left_nxt;
  logic                           timer_run_r, timer_run_nxt;
  logic [fbct_pkg::TimeW-1:0]     last_tick_r, last_tick_nxt;

  logic                           is_tick, tick_counts;
  logic [fbct_pkg::TimeW-1:0]     elapsed;
  logic [fbct_pkg::MsW-1:0]       fcd_left, bcd_left, tcd_left;
  logic                           fcd_run, bcd_run, tcd_run;
  logic                           focus_end, break_end;
  logic [fbct_pkg::MsW-1:0]       focus_len;
  logic                           focus_len_nz, break_len_nz;
  logic                           session_running;

  assign is_tick     = (cmd.op == fbct_pkg::OP_TICK);
  // a tick after a zero timestamp only records the time
  assign tick_counts = is_tick && (last_tick_r != '0);
  assign elapsed     = cmd.now_ms - last_tick_r;

  fbct_countdown u_focus_cd (
    .apply    (tick_counts && (phase_r == fbct_pkg::PH_FOCUS)),
    .left     (focus_left_r),
    .run      (focus_run_r),
    .elapsed  (elapsed),
    .left_nxt (fcd_left),
    .run_nxt  (fcd_run)
  );

  fbct_countdown u_break_cd (
    .apply    (tick_counts && (phase_r == fbct_pkg::PH_BREAK)),
    .left     (break_left_r),
    .run      (break_run_r),
    .elapsed  (elapsed),
    .left_nxt (bcd_left),
    .run_nxt  (bcd_run)
  );

  fbct_countdown u_timer_cd (
    .apply    (tick_counts),
    .left     (timer_left_r),
    .run      (timer_run_r),
    .elapsed  (elapsed),
    .left_nxt (tcd_left),
    .run_nxt  (tcd_run)
  );

  assign focus_end    = tick_counts && (phase_r == fbct_pkg::PH_FOCUS) &&
                        !fcd_run && (fcd_left == '0);
  assign break_end    = tick_counts && (phase_r == fbct_pkg::PH_BREAK) &&
                        !bcd_run && (bcd_left == '0);
  // start_ms is zero only when the command gave zero seconds
  assign focus_len    = (cmd.start_ms != '0) ? cmd.start_ms : focus_preset_ms;
  assign focus_len_nz = (focus_len != '0);
  assign break_len_nz = (break_preset_ms != '0);

  // phase transitions
  always_comb begin
    phase_nxt = phase_r;
    case (cmd.op)
      fbct_pkg::OP_TICK: begin
        if (focus_end) begin
          phase_nxt = (break_total_r != '0) ? fbct_pkg::PH_BREAK : fbct_pkg::PH_DONE;
        end else if (break_end) begin
          phase_nxt = fbct_pkg::PH_DONE;
        end
      end
      fbct_pkg::OP_START_FOCUS: begin
        if (focus_len_nz) begin
          phase_nxt = fbct_pkg::PH_FOCUS;
        end else if (break_len_nz) begin
          phase_nxt = fbct_pkg::PH_BREAK;
        end else begin
          phase_nxt = fbct_pkg::PH_DONE;
        end
      end
      fbct_pkg::OP_RESET_FOCUS: phase_nxt = fbct_pkg::PH_IDLE;
      default:                  phase_nxt = phase_r;
    endcase
  end

  // countdown values and flags
  always_comb begin
    focus_left_nxt  = focus_left_r;
    focus_run_nxt   = focus_run_r;
    break_total_nxt = break_total_r;
    break_left_nxt  = break_left_r;
    break_run_nxt   = break_run_r;
    timer_left_nxt  = timer_left_r;
    timer_run_nxt   = timer_run_r;
    last_tick_nxt   = last_tick_r;
    case (cmd.op)
      fbct_pkg::OP_TICK: begin
        last_tick_nxt  = cmd.now_ms;
        focus_left_nxt = fcd_left;
        focus_run_nxt  = fcd_run;
        break_left_nxt = bcd_left;
        break_run_nxt  = focus_end ? (break_total_r != '0) : bcd_run;
        timer_left_nxt = tcd_left;
        timer_run_nxt  = tcd_run;
      end
      fbct_pkg::OP_START_FOCUS: begin
        focus_left_nxt  = focus_len;
        focus_run_nxt   = focus_len_nz;
        break_total_nxt = break_preset_ms;
        break_left_nxt  = break_preset_ms;
        break_run_nxt   = !focus_len_nz && break_len_nz;
      end
      fbct_pkg::OP_PAUSE_FOCUS: begin
        if ((phase_r == fbct_pkg::PH_FOCUS) && (focus_left_r != '0)) begin
          focus_run_nxt = !focus_run_r;
        end else if ((phase_r == fbct_pkg::PH_BREAK) && (break_left_r != '0)) begin
          break_run_nxt = !break_run_r;
        end
      end
      fbct_pkg::OP_RESET_FOCUS: begin
        focus_left_nxt  = '0;
        focus_run_nxt   = 1'b0;
        break_total_nxt = '0;
        break_left_nxt  = '0;
        break_run_nxt   = 1'b0;
      end
      fbct_pkg::OP_START_TIMER: begin
        timer_left_nxt = cmd.start_ms;
        timer_run_nxt  = 1'b1;
      end
      fbct_pkg::OP_PAUSE_TIMER: timer_run_nxt = !timer_run_r;
      fbct_pkg::OP_RESET_TIMER: begin
        timer_left_nxt = '0;
        timer_run_nxt  = 1'b0;
      end
      default: begin
        last_tick_nxt = last_tick_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= fbct_pkg::PH_IDLE;
      focus_left_r  <= '0;
      focus_run_r   <= 1'b0;
      break_total_r <= '0;
      break_left_r  <= '0;
      break_run_r   <= 1'b0;
      timer_left_r  <= '0;
      timer_run_r   <= 1'b0;
      last_tick_r   <= '0;
    end else if (fire) begin
      phase_r       <= phase_nxt;
      focus_left_r  <= focus_left_nxt;
      focus_run_r   <= focus_run_nxt;
      break_total_r <= break_total_nxt;
      break_left_r  <= break_left_nxt;
      break_run_r   <= break_run_nxt;
      timer_left_r  <= timer_left_nxt;
      timer_run_r   <= timer_run_nxt;
      last_tick_r   <= last_tick_nxt;
    end
  end

  // status outputs
  always_comb begin
    case (phase_r)
      fbct_pkg::PH_FOCUS: session_running = focus_run_r;
      fbct_pkg::PH_BREAK: session_running = break_run_r;
      default:            session_running = 1'b0;
    endcase
    status.phase           = phase_r;
    status.focus_left_ms   = focus_left_r;
    status.focus_active    = focus_run_r;
    status.break_left_ms   = break_left_r;
    status.break_active    = break_run_r;
    status.timer_left_ms   = timer_left_r;
    status.timer_active    = timer_run_r;
    status.session_running = session_running;
  end

endmodule

`default_nettype wire

>>> src/fbct_checker.sv
// port-level checks for the focus/break countdown timer, bound to the top level
`default_nettype none

`include "focus_break_countdown_timer_macros.svh"

module fbct_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [1:0]                    out_phase,
  input  wire logic [fbct_pkg::MsW-1:0]      out_focus_left_ms,
  input  wire logic                          out_focus_active,
  input  wire logic [fbct_pkg::MsW-1:0]      out_break_left_ms,
  input  wire logic                          out_break_active,
  input  wire logic [fbct_pkg::MsW-1:0]      out_timer_left_ms,
  input  wire logic                          out_session_running
);

  logic out_held;
  logic phase_has_run;
  logic idle_clear;

  assign out_held      = out_valid && out_stall;
  assign phase_has_run = (out_phase == fbct_pkg::PH_FOCUS) ||
                         (out_phase == fbct_pkg::PH_BREAK);
  assign idle_clear    = (out_focus_left_ms == '0) && !out_focus_active &&
                         (out_break_left_ms == '0) && !out_break_active;

  // a stalled result keeps its status
  `FBCT_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(out_phase) && $stable(out_focus_left_ms) && $stable(out_break_left_ms) && $stable(out_timer_left_ms) && $stable(out_session_running))

  // only focus or break can report a running session
  `FBCT_ASSERT_NOW(a_sess_phase, out_valid && out_session_running, phase_has_run)

  // an idle session holds no focus or break time and neither of them runs
  `FBCT_ASSERT_NOW(a_idle_clear, out_valid && (out_phase == fbct_pkg::PH_IDLE), idle_clear)

  // the focus countdown never runs with nothing left
  `FBCT_ASSERT_NOW(a_focus_run_left, out_valid && out_focus_active, out_focus_left_ms != '0)

endmodule

bind focus_break_countdown_timer fbct_checker u_fbct_checker (.*);

`default_nettype wire

>>> test/tb_focus_break_countdown_timer.sv
`timescale 1ns / 100ps
// self-checking testbench of the focus/break countdown timer with a status predictor
module tb_focus_break_countdown_timer;
  import fbct_pkg::*;

  localparam logic [OpW-1:0]  OP_UNUSED     = 3'd7;
  localparam logic [SecW-1:0] SEC_FIELD_MAX = 17'h1FFFF;
  localparam int QUIET_LIMIT    = 4000;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 6;
  localparam int PHASE_ITEMS    = 470;
  localparam int PRINT_CAP      = 100;

  class session_tracker;
    logic [SecW-1:0]  focus_preset_s;
    logic [SecW-1:0]  break_preset_s;
    phase_t           phase;
    logic [MsW-1:0]   focus_left;
    logic [MsW-1:0]   break_total;
    logic [MsW-1:0]   break_left;
    logic [MsW-1:0]   timer_left;
    bit               focus_on;
    bit               break_on;
    bit               timer_on;
    logic [TimeW-1:0] last_tick_ms;
    status_t          pending_status[$];
    int               mismatches;

    function new();
      focus_preset_s = 17'd1500;
      break_preset_s = 17'd300;
      phase          = PH_IDLE;
      focus_left     = '0;
      break_total    = '0;
      break_left     = '0;
      timer_left     = '0;
      focus_on       = 1'b0;
      break_on       = 1'b0;
      timer_on       = 1'b0;
      last_tick_ms   = '0;
      mismatches     = 0;
    endfunction

    function logic [MsW-1:0] seconds_to_ms(input logic [SecW-1:0] secs);
      logic [SecW-1:0] clipped;
      clipped = (secs > MAX_SECONDS) ? MAX_SECONDS : secs;
      return MsW'(MsW'(clipped) * MS_PER_SEC);
    endfunction

    function void set_preset(input logic [IdxW-1:0] idx, input logic [SecW-1:0] value);
      if (idx == REG_FOCUS_PRESET) begin
        focus_preset_s = value;
      end else if (idx == REG_BREAK_PRESET) begin
        break_preset_s = value;
      end
    endfunction

    // saturating countdown of one running counter
    function void run_down(inout logic [MsW-1:0] left, inout bit run,
                           input logic [TimeW-1:0] elapsed);
      if (!run || left == 0) begin
        if (left == 0) run = 1'b0;
      end else if (elapsed >= TimeW'(left)) begin
        left = '0;
        run  = 1'b0;
      end else begin
        left = left - MsW'(elapsed);
      end
    endfunction

    function void tick(input logic [TimeW-1:0] now);
      logic [TimeW-1:0] elapsed;
      if (last_tick_ms == 0) begin
        last_tick_ms = now;
        return;
      end
      elapsed = now - last_tick_ms;
      if (phase == PH_FOCUS) begin
        run_down(focus_left, focus_on, elapsed);
        if (!focus_on && focus_left == 0) begin
          break_on = (break_total != 0);
          if (break_on) phase = PH_BREAK;
          else phase = PH_DONE;
        end
      end else if (phase == PH_BREAK) begin
        run_down(break_left, break_on, elapsed);
        if (!break_on && break_left == 0) phase = PH_DONE;
      end
      run_down(timer_left, timer_on, elapsed);
      last_tick_ms = now;
    endfunction

    function void start_focus(input logic [SecW-1:0] secs);
      focus_left  = (secs == 0) ? seconds_to_ms(focus_preset_s) : seconds_to_ms(secs);
      focus_on    = (focus_left != 0);
      break_total = seconds_to_ms(break_preset_s);
      break_left  = break_total;
      break_on    = 1'b0;
      if (focus_on) begin
        phase = PH_FOCUS;
      end else if (break_total != 0) begin
        break_on = 1'b1;
        phase    = PH_BREAK;
      end else begin
        phase = PH_DONE;
      end
    endfunction

    // accepted request: update the state and queue the status it returns
    function void apply_command(input logic [OpW-1:0] op, input logic [TimeW-1:0] now,
                                input logic [SecW-1:0] secs);
      status_t s;
      case (op)
        OP_TICK:        tick(now);
        OP_START_FOCUS: start_focus(secs);
        OP_PAUSE_FOCUS: begin
          if (phase == PH_FOCUS && focus_left != 0) focus_on = !focus_on;
          else if (phase == PH_BREAK && break_left != 0) break_on = !break_on;
        end
        OP_RESET_FOCUS: begin
          focus_left  = '0;
          focus_on    = 1'b0;
          break_total = '0;
          break_left  = '0;
          break_on    = 1'b0;
          phase       = PH_IDLE;
        end
        OP_START_TIMER: begin
          timer_left = seconds_to_ms(secs);
          timer_on   = 1'b1;
        end
        OP_PAUSE_TIMER: timer_on = !timer_on;
        OP_RESET_TIMER: begin
          timer_left = '0;
          timer_on   = 1'b0;
        end
        default: ;
      endcase
      s.phase           = phase;
      s.focus_left_ms   = focus_left;
      s.focus_active    = focus_on;
      s.break_left_ms   = break_left;
      s.break_active    = break_on;
      s.timer_left_ms   = timer_left;
      s.timer_active    = timer_on;
      if (phase == PH_FOCUS) s.session_running = focus_on;
      else if (phase == PH_BREAK) s.session_running = break_on;
      else s.session_running = 1'b0;
      pending_status.push_back(s);
    endfunction

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      if (mismatches < PRINT_CAP)
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_status(input status_t got);
      status_t want;
      if (pending_status.size() == 0) begin
        report_mismatch("result with no request pending", 32'd0, 32'd0);
        return;
      end
      want = pending_status.pop_front();
      if (got.phase !== want.phase)
        report_mismatch("phase", 32'(got.phase), 32'(want.phase));
      if (got.focus_left_ms !== want.focus_left_ms)
        report_mismatch("focus_left_ms", 32'(got.focus_left_ms), 32'(want.focus_left_ms));
      if (got.focus_active !== want.focus_active)
        report_mismatch("focus_active", 32'(got.focus_active), 32'(want.focus_active));
      if (got.break_left_ms !== want.break_left_ms)
        report_mismatch("break_left_ms", 32'(got.break_left_ms), 32'(want.break_left_ms));
      if (got.break_active !== want.break_active)
        report_mismatch("break_active", 32'(got.break_active), 32'(want.break_active));
      if (got.timer_left_ms !== want.timer_left_ms)
        report_mismatch("timer_left_ms", 32'(got.timer_left_ms), 32'(want.timer_left_ms));
      if (got.timer_active !== want.timer_active)
        report_mismatch("timer_active", 32'(got.timer_active), 32'(want.timer_active));
      if (got.session_running !== want.session_running)
        report_mismatch("session_running", 32'(got.session_running),
                        32'(want.session_running));
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [OpW-1:0]      in_op;
  logic [TimeW-1:0]    in_now_ms;
  logic [SecW-1:0]     in_start_seconds;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_phase;
  logic [MsW-1:0]      out_focus_left_ms;
  logic                out_focus_active;
  logic [MsW-1:0]      out_break_left_ms;
  logic                out_break_active;
  logic [MsW-1:0]      out_timer_left_ms;
  logic                out_timer_active;
  logic                out_session_running;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IdxW-1:0]     cfg_index;
  logic [SecW-1:0]     cfg_data;

  session_tracker tracker;
  status_t        seen_status;
  int             items_sent;
  int             quiet_cycles;
  int             send_idle_pct;
  int             recv_stall_pct;
  bit             holdoff_armed;
  logic [TimeW-1:0] clock_ms;

  focus_break_countdown_timer u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_op               (in_op),
    .in_now_ms           (in_now_ms),
    .in_start_seconds    (in_start_seconds),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_phase           (out_phase),
    .out_focus_left_ms   (out_focus_left_ms),
    .out_focus_active    (out_focus_active),
    .out_break_left_ms   (out_break_left_ms),
    .out_break_active    (out_break_active),
    .out_timer_left_ms   (out_timer_left_ms),
    .out_timer_active    (out_timer_active),
    .out_session_running (out_session_running),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // receiver: random stalls, plus a long hold-off when armed
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_armed) begin
        holdoff_armed = 1'b0;
        repeat (HOLDOFF_CYCLES) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen_status.phase           = out_phase;
        seen_status.focus_left_ms   = out_focus_left_ms;
        seen_status.focus_active    = out_focus_active;
        seen_status.break_left_ms   = out_break_left_ms;
        seen_status.break_active    = out_break_active;
        seen_status.timer_left_ms   = out_timer_left_ms;
        seen_status.timer_active    = out_timer_active;
        seen_status.session_running = out_session_running;
        tracker.check_status(seen_status);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("focus_break_countdown_timer regression: fail");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [OpW-1:0] op, input logic [TimeW-1:0] now,
                              input logic [SecW-1:0] secs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_op            <= op;
    in_now_ms        <= now;
    in_start_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.apply_command(op, now, secs);
    items_sent++;
  endtask

  task automatic send_tick(input logic [TimeW-1:0] now);
    send_command(OP_TICK, now, 17'($urandom));
  endtask

  task automatic write_preset(input logic [IdxW-1:0] idx, input logic [SecW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_preset(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // block is idle once every status is back and the pipeline has emptied
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [SecW-1:0] pick_seconds();
    int r;
    r = $urandom_range(99);
    if (r < 30) return '0;
    if (r < 80) return SecW'($urandom_range(1, 12));
    if (r < 92) return SecW'($urandom_range(13, 200));
    if (r < 96) return MAX_SECONDS;
    return SecW'($urandom_range(86400, 131071));
  endfunction

  function automatic logic [TimeW-1:0] tick_step();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 92) return TimeW'($urandom_range(1, 3000));
    return TimeW'($urandom_range(3001, 120000));
  endfunction

  // mostly a focus session with ticks, sometimes a stray random request
  task automatic run_random_burst();
    int steps;
    if ($urandom_range(99) < 15) begin
      send_command(3'($urandom_range(7)), $urandom, 17'($urandom));
    end else begin
      if ($urandom_range(3) == 0) send_command(OP_START_TIMER, $urandom, pick_seconds());
      send_command(OP_START_FOCUS, $urandom, pick_seconds());
      steps = $urandom_range(3, 14);
      repeat (steps) begin
        case ($urandom_range(19))
          0, 1: send_command(OP_PAUSE_FOCUS, $urandom, 17'($urandom));
          2:    send_command(OP_PAUSE_TIMER, $urandom, 17'($urandom));
          3:    send_command(OP_RESET_TIMER, $urandom, 17'($urandom));
          4:    send_command(OP_RESET_FOCUS, $urandom, 17'($urandom));
          default: begin
            clock_ms = clock_ms + tick_step();
            send_tick(clock_ms);
          end
        endcase
      end
    end
  endtask

  initial begin
    int target;
    tracker          = new();
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_op            = OP_TICK;
    in_now_ms        = '0;
    in_start_seconds = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_FOCUS_PRESET;
    cfg_data         = '0;
    items_sent       = 0;
    quiet_cycles     = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    holdoff_armed    = 1'b0;
    clock_ms         = 32'd1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first tick at zero, unused code, default focus, pausing, wrap
    send_tick(32'd0);
    send_command(OP_UNUSED, 32'hFFFF_FFFF, SEC_FIELD_MAX);
    send_command(OP_START_FOCUS, 32'd0, 17'd0);
    send_tick(32'd1000);
    send_tick(32'd61000);
    send_command(OP_PAUSE_FOCUS, 32'd0, 17'd0);
    send_tick(32'd70000);
    send_command(OP_PAUSE_FOCUS, 32'd0, 17'd0);
    send_command(OP_START_TIMER, 32'd0, SEC_FIELD_MAX);
    // huge elapsed ends focus and timer, then the wrap gives a small step
    send_tick(32'hFFFF_FFF0);
    send_tick(32'h0000_0010);
    send_command(OP_PAUSE_FOCUS, 32'd0, 17'd0);
    send_command(OP_PAUSE_FOCUS, 32'd0, 17'd0);
    // tick at zero moves the counters, next tick only records
    send_tick(32'd0);
    send_tick(32'd500000);
    send_tick(32'd900000);
    send_command(OP_PAUSE_FOCUS, 32'd0, 17'd0);
    send_command(OP_START_TIMER, 32'd0, 17'd0);
    send_tick(32'd900001);
    send_command(OP_PAUSE_TIMER, 32'd0, 17'd0);
    send_command(OP_RESET_TIMER, 32'd0, 17'd0);
    send_command(OP_START_FOCUS, 32'd0, MAX_SECONDS);
    send_command(OP_START_FOCUS, 32'd0, SEC_FIELD_MAX);
    send_command(OP_RESET_FOCUS, 32'd0, 17'd0);

    // zero focus length goes straight to complete, or to a running break
    drain_results();
    write_preset(REG_FOCUS_PRESET, 17'd0);
    write_preset(REG_BREAK_PRESET, 17'd0);
    send_command(OP_START_FOCUS, 32'd0, 17'd0);
    drain_results();
    write_preset(REG_BREAK_PRESET, 17'd5);
    send_command(OP_START_FOCUS, 32'd0, 17'd0);
    clock_ms = 32'd900001;

    for (int p = 0; p < 4; p++) begin
      drain_results();
      case (p)
        0: begin
          write_preset(REG_FOCUS_PRESET, 17'd2);
          write_preset(REG_BREAK_PRESET, 17'd3);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          holdoff_armed  = 1'b1;
        end
        1: begin
          write_preset(REG_FOCUS_PRESET, MAX_SECONDS);
          write_preset(REG_BREAK_PRESET, 17'd0);
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          write_preset(REG_FOCUS_PRESET, SEC_FIELD_MAX);
          write_preset(REG_BREAK_PRESET, SEC_FIELD_MAX);
          send_idle_pct  = 0;
          recv_stall_pct = 68;
          holdoff_armed  = 1'b1;
          clock_ms       = 32'hFFFF_0000;
        end
        default: begin
          write_preset(REG_FOCUS_PRESET, 17'd0);
          write_preset(REG_BREAK_PRESET, 17'd1);
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) run_random_burst();
    end

    drain_results();
    if (tracker.mismatches == 0 && tracker.pending_status.size() == 0) begin
      $display("focus_break_countdown_timer regression: pass");
    end else begin
      $display("focus_break_countdown_timer regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/fbct_pkg.sv
src/fbct_countdown.sv
src/fbct_exec.sv
src/focus_break_countdown_timer.sv
src/fbct_checker.sv
test/tb_focus_break_countdown_timer.sv
